[rtl/epsf_pkg.sv]
// ----------------------------------------------------------------------------
// epsf_pkg
// Shared constants, width helpers and state encoding for the equal partition
// subset finder.
// ----------------------------------------------------------------------------
`default_nettype none

package epsf_pkg;

  localparam int MAX_ITEMS_D = 32;
  localparam int SIZE_BITS_D = 8;
  localparam int WORD_BITS_D = 64;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_FIN_RD,
    ST_FIN_CHK,
    ST_BT_RD,
    ST_BT_CHK
  } back_state_t;

  function automatic int cnt_w(input int max_items);
    return $clog2(max_items + 1);
  endfunction

  function automatic int tot_w(input int max_items, input int size_bits);
    return $clog2(max_items * ((1 << size_bits) - 1) + 1);
  endfunction

  // size, row, update, last, count, total, overflow
  function automatic int cmd_w(input int max_items, input int size_bits);
    return size_bits + 2 * cnt_w(max_items) + 3 + tot_w(max_items, size_bits);
  endfunction

  // found, is_member, size, index, overflow, last
  function automatic int res_w(input int max_items, input int size_bits);
    return size_bits + cnt_w(max_items) + 4;
  endfunction

endpackage

`default_nettype wire

[rtl/equal_partition_subset_finder_core.sv]
// ----------------------------------------------------------------------------
// equal_partition_subset_finder_core
// Decides whether a set of item sizes splits into two equal-sum halves and
// lists the members of one half.
// ----------------------------------------------------------------------------
// Each item streams its ROW_WORDS reachable-sum row words through the row
// engine, one per cycle, through the row memory port pair. The last item
// then checks the half sum for the header and backtracks, visiting at most
// one row per item of the set.
// Synchronous reset clears both queues, counters and the engine state; the
// row memory needs no clearing because every row is written before use.
`default_nettype none

module equal_partition_subset_finder_core import epsf_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_D,
  parameter int SIZE_BITS = SIZE_BITS_D,
  parameter int WORD_BITS = WORD_BITS_D
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [SIZE_BITS-1:0]         item_size,
  input  wire logic                         last,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              found,
  output logic                              is_member,
  output logic [SIZE_BITS-1:0]              member_size,
  output logic [cnt_w(MAX_ITEMS)-1:0]       member_index,
  output logic                              overflow_error,
  output logic                              last_result
);

  localparam int CMDW = cmd_w(MAX_ITEMS, SIZE_BITS);
  localparam int RESW = res_w(MAX_ITEMS, SIZE_BITS);

  logic            cmd_push;
  logic [CMDW-1:0] cmd_in;
  logic [CMDW-1:0] cmd_out;
  logic            cmd_empty;
  logic            cmd_pop;
  logic [RESW-1:0] res_in;
  logic [RESW-1:0] res_out;
  logic            res_push;
  logic            res_full;

  epsf_front #(
    .MAX_ITEMS(MAX_ITEMS),
    .SIZE_BITS(SIZE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd_full (full),
    .item_size(item_size),
    .last     (last),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  epsf_fifo #(
    .WIDTH(CMDW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (cmd_push),
    .wr_data(cmd_in),
    .full   (full),
    .rd_en  (cmd_pop),
    .rd_data(cmd_out),
    .empty  (cmd_empty)
  );

  epsf_back #(
    .MAX_ITEMS(MAX_ITEMS),
    .SIZE_BITS(SIZE_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_data (cmd_out),
    .cmd_empty(cmd_empty),
    .cmd_pop  (cmd_pop),
    .out_data (res_in),
    .out_push (res_push),
    .out_full (res_full)
  );

  epsf_fifo #(
    .WIDTH(RESW),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_push),
    .wr_data(res_in),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(res_out),
    .empty  (empty)
  );

  assign {found, is_member, member_size, member_index, overflow_error, last_result} = res_out;

endmodule

`default_nettype wire

[rtl/epsf_fifo.sv]
// ----------------------------------------------------------------------------
// epsf_fifo
// Small register queue with full/empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module epsf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [NW-1:0]    used;
  logic             do_wr;
  logic             do_rd;

  assign full    = (used == NW'(DEPTH));
  assign empty   = (used == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      used <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        used <= used + 1'b1;
      end else if (do_rd && !do_wr) begin
        used <= used - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/epsf_front.sv]
// ----------------------------------------------------------------------------
// epsf_front
// Accepts item sizes, tracks count, running total and overflow per set, and
// issues one command per item to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module epsf_front import epsf_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_D,
  parameter int SIZE_BITS = SIZE_BITS_D
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  input  wire logic                                   cmd_full,
  input  wire logic [SIZE_BITS-1:0]                   item_size,
  input  wire logic                                   last,
  output logic                                        cmd_push,
  output logic [cmd_w(MAX_ITEMS, SIZE_BITS)-1:0]      cmd_data
);

  localparam int CW = cnt_w(MAX_ITEMS);
  localparam int TW = tot_w(MAX_ITEMS, SIZE_BITS);

  logic [CW-1:0] item_count;
  logic [TW-1:0] running_total;
  logic          overflow_flag;

  logic          upd;
  logic [CW-1:0] cnt_next;
  logic [TW-1:0] total_next;
  logic          ovf_next;

  assign cmd_push   = push && !cmd_full;
  assign upd        = (item_count < CW'(MAX_ITEMS));
  assign cnt_next   = upd ? item_count + 1'b1 : item_count;
  assign total_next = upd ? running_total + TW'(item_size) : running_total;
  assign ovf_next   = overflow_flag || !upd;
  assign cmd_data   = {item_size, item_count, upd, last, cnt_next, total_next, ovf_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      running_total <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd_push) begin
      if (last) begin
        item_count    <= '0;
        running_total <= '0;
        overflow_flag <= 1'b0;
      end else begin
        item_count    <= cnt_next;
        running_total <= total_next;
        overflow_flag <= ovf_next;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/epsf_back.sv]
// ----------------------------------------------------------------------------
// epsf_back
// Reachable-sum row engine: streams one row word per cycle through the row
// memory for each item, then checks the half sum and backtracks.
// ----------------------------------------------------------------------------
`default_nettype none

module epsf_back import epsf_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_D,
  parameter int SIZE_BITS = SIZE_BITS_D,
  parameter int WORD_BITS = WORD_BITS_D
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [cmd_w(MAX_ITEMS, SIZE_BITS)-1:0] cmd_data,
  input  wire logic                                   cmd_empty,
  output logic                                        cmd_pop,
  output logic [res_w(MAX_ITEMS, SIZE_BITS)-1:0]      out_data,
  output logic                                        out_push,
  input  wire logic                                   out_full
);

  localparam int SIZE_MASK = (1 << SIZE_BITS) - 1;
  localparam int HALF_MAX  = (MAX_ITEMS * SIZE_MASK) / 2;
  localparam int ROW_WORDS = (HALF_MAX + WORD_BITS) / WORD_BITS;
  localparam int DEPTH     = MAX_ITEMS * ROW_WORDS;
  localparam int AW        = $clog2(DEPTH);
  localparam int WCW       = $clog2(ROW_WORDS + 1);
  localparam int BW        = $clog2(WORD_BITS);
  localparam int CW        = cnt_w(MAX_ITEMS);
  localparam int TW        = tot_w(MAX_ITEMS, SIZE_BITS);
  localparam int HW        = $clog2(HALF_MAX + 1);
  localparam int SI        = $clog2(MAX_ITEMS);

  // command fields
  logic [SIZE_BITS-1:0] c_size;
  logic [CW-1:0]        c_row;
  logic                 c_upd;
  logic                 c_last;
  logic [CW-1:0]        c_cnt;
  logic [TW-1:0]        c_total;
  logic                 c_ovf;

  assign {c_size, c_row, c_upd, c_last, c_cnt, c_total, c_ovf} = cmd_data;

  back_state_t state;
  back_state_t state_next;

  // row k is stored at (k-1)*ROW_WORDS; row 0 is implied (sum zero only)
  logic [WORD_BITS-1:0] rows_mem [DEPTH];
  logic [SIZE_BITS-1:0] sizes_mem [MAX_ITEMS];

  logic [AW-1:0]        ra_addr;
  logic [AW-1:0]        rb_addr;
  logic [AW-1:0]        wa;
  logic [WORD_BITS-1:0] wd;
  logic [WORD_BITS-1:0] ra_data;
  logic [WORD_BITS-1:0] rb_data;
  logic [SIZE_BITS-1:0] sz_q;

  // update stream
  logic [CW-1:0]        k;
  logic [SIZE_BITS-1:0] q;
  logic [BW-1:0]        r;
  logic [WCW-1:0]       w;
  logic                 s1_v;
  logic [WCW-1:0]       s1_w;
  logic                 s1_az;
  logic                 s1_bz;
  logic                 s1_bv;
  logic [WORD_BITS-1:0] bprev;
  logic [WORD_BITS-1:0] a_eff;
  logic [WORD_BITS-1:0] b_eff;
  logic [WORD_BITS-1:0] shifted;

  // finish and backtrack
  logic [CW-1:0]        lr;
  logic [HW-1:0]        target;
  logic                 f_last;
  logic                 f_ovf;
  logic                 f_odd;
  logic                 chk_bit;
  logic                 hdr_found;
  logic                 mem_last;

  always_comb begin
    if (state == ST_UPD) begin
      ra_addr = AW'((32'(k) - 32'd1) * 32'(ROW_WORDS) + 32'(w));
      rb_addr = AW'((32'(k) - 32'd1) * 32'(ROW_WORDS) + 32'(w) - 32'(q));
    end else begin
      ra_addr = AW'((32'(lr) - 32'd1) * 32'(ROW_WORDS) + (32'(target) >> BW));
      rb_addr = ra_addr;
    end
  end

  assign wa = AW'(32'(k) * 32'(ROW_WORDS) + 32'(s1_w));

  always_ff @(posedge clk) begin
    if (s1_v) begin
      rows_mem[wa] <= wd;
    end
    ra_data <= rows_mem[ra_addr];
    rb_data <= rows_mem[rb_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && c_upd) begin
      sizes_mem[c_row[SI-1:0]] <= c_size;
    end
    sz_q <= sizes_mem[lr[SI-1:0]];
  end

  // new row word = old word | old row shifted up by the item size
  always_comb begin
    if (k == '0) begin
      a_eff = s1_az ? WORD_BITS'(1) : '0;
    end else begin
      a_eff = ra_data;
    end
    if (!s1_bv) begin
      b_eff = '0;
    end else if (k == '0) begin
      b_eff = s1_bz ? WORD_BITS'(1) : '0;
    end else begin
      b_eff = rb_data;
    end
    if (r == '0) begin
      shifted = b_eff;
    end else begin
      shifted = (b_eff << r) | (bprev >> (WORD_BITS - int'(r)));
    end
    wd = a_eff | shifted;
  end

  assign chk_bit   = (lr == '0) ? (target == '0) : ra_data[target[BW-1:0]];
  assign hdr_found = !f_ovf && !f_odd && chk_bit;
  assign mem_last  = (32'(target) == 32'(sz_q));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    out_push   = 1'b0;
    out_data   = {1'b1, 1'b1, sz_q, lr + 1'b1, 1'b0, mem_last};
    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (c_upd) begin
            state_next = ST_UPD;
          end else if (c_last) begin
            state_next = ST_FIN_RD;
          end
        end
      end
      ST_UPD: begin
        if (w == WCW'(ROW_WORDS)) begin
          state_next = f_last ? ST_FIN_RD : ST_IDLE;
        end
      end
      ST_FIN_RD: begin
        state_next = ST_FIN_CHK;
      end
      ST_FIN_CHK: begin
        out_data = {hdr_found, 1'b0, {SIZE_BITS{1'b0}}, {CW{1'b0}}, f_ovf,
                    !hdr_found || (target == '0)};
        if (!out_full) begin
          out_push   = 1'b1;
          state_next = (hdr_found && target != '0) ? ST_BT_RD : ST_IDLE;
        end
      end
      ST_BT_RD: begin
        state_next = ST_BT_CHK;
      end
      ST_BT_CHK: begin
        if (chk_bit) begin
          state_next = (lr == '0) ? ST_IDLE : ST_BT_RD;
        end else if (!out_full) begin
          out_push   = 1'b1;
          state_next = mem_last ? ST_IDLE : ST_BT_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= (state == ST_UPD) && (w != WCW'(ROW_WORDS));
    end
  end

  always_ff @(posedge clk) begin
    s1_w  <= w;
    s1_az <= (w == '0);
    s1_bv <= (32'(w) >= 32'(q));
    s1_bz <= (32'(w) == 32'(q));
    if (s1_v) begin
      bprev <= b_eff;
    end
    if (state == ST_UPD && w != WCW'(ROW_WORDS)) begin
      w <= w + 1'b1;
    end
    if (state == ST_FIN_CHK && out_push) begin
      lr <= lr - 1'b1;
    end
    if (state == ST_BT_CHK) begin
      if (chk_bit) begin
        lr <= lr - 1'b1;
      end else if (out_push) begin
        lr     <= lr - 1'b1;
        target <= target - HW'(sz_q);
      end
    end
    if (cmd_pop) begin
      k      <= c_row;
      q      <= SIZE_BITS'(32'(c_size) >> BW);
      r      <= BW'(32'(c_size));
      w      <= '0;
      bprev  <= '0;
      f_last <= c_last;
      f_ovf  <= c_ovf;
      f_odd  <= c_total[0];
      target <= HW'(c_total >> 1);
      lr     <= c_cnt;
    end
  end

endmodule

`default_nettype wire

[rtl/epsf_checker.sv]
// ----------------------------------------------------------------------------
// epsf_checker
// Port-level assertions on the result stream of the subset finder.
// ----------------------------------------------------------------------------
`default_nettype none

module epsf_checker import epsf_pkg::*; #(
  parameter int MAX_ITEMS = MAX_ITEMS_D,
  parameter int SIZE_BITS = SIZE_BITS_D
) (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         empty,
  input wire logic                         pop,
  input wire logic                         found,
  input wire logic                         is_member,
  input wire logic [SIZE_BITS-1:0]         member_size,
  input wire logic [cnt_w(MAX_ITEMS)-1:0]  member_index,
  input wire logic                         overflow_error,
  input wire logic                         last_result
);

  // a waiting result is not withdrawn
  a_res_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty)
    else $error("result withdrawn before transfer");

  a_member_found: assert property (@(posedge clk) disable iff (rst)
    !empty && is_member |-> found && !overflow_error && member_index != '0
      && member_size != '0)
    else $error("member result outside a found run");

  a_ovf_header: assert property (@(posedge clk) disable iff (rst)
    !empty && overflow_error |-> !found && !is_member && last_result)
    else $error("overflow result is not a closing header");

  a_header_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !is_member |-> member_size == '0 && member_index == '0)
    else $error("header carries member fields");

  a_fail_closes: assert property (@(posedge clk) disable iff (rst)
    !empty && !found |-> last_result)
    else $error("not-found header does not close the run");

endmodule

bind equal_partition_subset_finder_core epsf_checker #(
  .MAX_ITEMS(MAX_ITEMS),
  .SIZE_BITS(SIZE_BITS)
) u_epsf_checker (.*);

`default_nettype wire
